// ===== design/rlmf_pkg.sv =====
// ----------------------------------------------------------------------------
// rlmf_pkg
// Shared types and constants of the raster local maximum finder.
// ----------------------------------------------------------------------------
`default_nettype none

package rlmf_pkg;

  // Item field widths.
  localparam int DATA_W     = 32;
  localparam int ROW_OUT_W  = 13;
  localparam int COL_OUT_W  = 11;
  localparam int CNT_W      = 23;
  localparam int OUT_DATA_W = 48;

  // Configuration port.
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_ROWS = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_COLS = 1'd1;

  // Default frame limits.
  localparam int MAX_COLS_DEF = 1024;
  localparam int MAX_ROWS_DEF = 4096;

  // Result queue: room for the three results one pixel can cause, plus slack.
  localparam int OQ_DEPTH = 8;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = OQ_PTR_W + 1;

  // One result item; the row sits in the lowest bits.
  typedef struct packed {
    logic                 last;
    logic [CNT_W-1:0]     count;
    logic [COL_OUT_W-1:0] col;
    logic [ROW_OUT_W-1:0] row;
  } result_t;

endpackage

`default_nettype wire

// ===== design/raster_local_maximum_finder_top.sv =====
// ----------------------------------------------------------------------------
// raster_local_maximum_finder_top
// Four-neighbor peak finder over a raster stream of signed pixels, with two
// line buffers in RAM and a small queue of result items.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_*       in         pixel (signed 32 bits), one item per pixel
//  m_*       out        peak_row, peak_col, peak_count; tlast on the final
//                       result caused by one pixel
//  cfg_*     in         register writes: frame_rows, frame_cols
//
// A pixel's results are decided in the cycle it is taken; the queue gives out
// one result per cycle while m_tready is high. s_tready stays high while the
// queue has room for three results, so pixels with at most one peak flow at
// one per cycle while m_tready is high; pixels with more peaks can fill the
// queue when the output drains one per cycle. Reset clears position, peak
// count and queue; the line buffers are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module raster_local_maximum_finder_top #(
  parameter int MAX_COLS = rlmf_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = rlmf_pkg::MAX_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration writes.
  input  logic                            cfg_we,
  input  logic [rlmf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [rlmf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // Pixel input.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [rlmf_pkg::DATA_W-1:0]     s_tdata,   // [31:0] pixel
  // Result output.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [rlmf_pkg::OUT_DATA_W-1:0] m_tdata,   // [12:0] peak_row,
                                                     // [23:13] peak_col,
                                                     // [46:24] peak_count,
                                                     // [47] zero
  output logic                            m_tlast
);

  import rlmf_pkg::*;

  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLS - 1);

  // Configuration registers.
  logic [12:0] frame_rows;
  logic [10:0] frame_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows <= 13'd1;
      frame_cols <= 11'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FRAME_ROWS: frame_rows <= cfg_wdata[12:0];
        REG_FRAME_COLS: frame_cols <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  // Effective frame sizes, clamped to 1..MAX.
  logic [31:0] rows_eff;
  logic [31:0] cols_eff;

  always_comb begin
    if (frame_rows == 13'd0) begin
      rows_eff = 32'd1;
    end else if (32'(frame_rows) > 32'(MAX_ROWS)) begin
      rows_eff = 32'(MAX_ROWS);
    end else begin
      rows_eff = 32'(frame_rows);
    end
    if (frame_cols == 11'd0) begin
      cols_eff = 32'd1;
    end else if (32'(frame_cols) > 32'(MAX_COLS)) begin
      cols_eff = 32'(MAX_COLS);
    end else begin
      cols_eff = 32'(frame_cols);
    end
  end

  // Position, peak total and neighbor registers.
  logic [ROW_W-1:0]         row_pos;
  logic [COL_W-1:0]         col_pos;
  logic [CNT_W-1:0]         peak_total;
  logic signed [DATA_W-1:0] left_pixel;
  logic signed [DATA_W-1:0] left2_pixel;
  logic signed [DATA_W-1:0] left_left_pixel;

  // Result queue state.
  result_t             oq_mem [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] oq_wptr;
  logic [OQ_PTR_W-1:0] oq_rptr;
  logic [OQ_CNT_W-1:0] oq_count;

  logic in_accept;
  logic out_accept;

  assign s_tready   = !rst && (oq_count <= OQ_CNT_W'(OQ_DEPTH - 3));
  assign in_accept  = s_tvalid && s_tready;
  assign m_tvalid   = (oq_count != '0);
  assign out_accept = m_tvalid && m_tready;

  // Position arithmetic of the current pixel.
  logic [31:0]      row_p1;
  logic [31:0]      col_p1;
  logic             last_row;
  logic             last_col;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;

  always_comb begin
    row_p1   = 32'(row_pos) + 32'd1;
    col_p1   = 32'(col_pos) + 32'd1;
    last_row = (row_p1 >= rows_eff);
    last_col = (col_p1 >= cols_eff);
    col_next = last_col ? '0 : COL_W'(col_p1);
    if (last_col) begin
      row_next = last_row ? '0 : ROW_W'(row_p1);
    end else begin
      row_next = row_pos;
    end
  end

  // Line buffer addresses: read ahead for the pixel that comes next.
  logic [COL_W-1:0] rd_addr;
  logic [COL_W-1:0] rd_addr_right;

  assign rd_addr       = in_accept ? col_next : col_pos;
  assign rd_addr_right = (rd_addr == COL_LAST) ? '0 : rd_addr + COL_W'(1);

  logic [2*DATA_W-1:0] rows_rdata;
  logic [DATA_W-1:0] prev_rdata;
  logic [DATA_W-1:0] prev_right_rdata;
  logic [DATA_W-1:0] prev2_rdata;
  logic signed [DATA_W-1:0] above;
  logic signed [DATA_W-1:0] above2;
  logic signed [DATA_W-1:0] right_above;
  logic signed [DATA_W-1:0] pixel;

  assign pixel = s_tdata;

  // Previous row (low half) and the row before it (high half), read at the
  // pixel's column.
  rlmf_ram #(.WIDTH(2 * DATA_W), .DEPTH(MAX_COLS)) u_rows_ram (
    .clk   (clk),
    .we    (in_accept),
    .waddr (col_pos),
    .wdata ({above, s_tdata}),
    .raddr (rd_addr),
    .rdata (rows_rdata)
  );

  assign prev_rdata  = rows_rdata[DATA_W-1:0];
  assign prev2_rdata = rows_rdata[2*DATA_W-1:DATA_W];

  // Copy of the previous row, read one column to the right.
  rlmf_ram #(.WIDTH(DATA_W), .DEPTH(MAX_COLS)) u_prev_right_ram (
    .clk   (clk),
    .we    (in_accept),
    .waddr (col_pos),
    .wdata (s_tdata),
    .raddr (rd_addr_right),
    .rdata (prev_right_rdata)
  );

  // Forwarding of a write that hit the address read at the same edge.
  logic              fwd_here;
  logic              fwd_right;
  logic [DATA_W-1:0] fwd_pixel;
  logic [DATA_W-1:0] fwd_above;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_here  <= 1'b0;
      fwd_right <= 1'b0;
    end else begin
      fwd_here  <= in_accept && (col_pos == rd_addr);
      fwd_right <= in_accept && (col_pos == rd_addr_right);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      fwd_pixel <= s_tdata;
      fwd_above <= above;
    end
  end

  assign above       = fwd_here ? fwd_pixel : prev_rdata;
  assign above2      = fwd_here ? fwd_above : prev2_rdata;
  assign right_above = fwd_right ? fwd_pixel : prev_right_rdata;

  // Peak decisions for the pixel above, the left pixel and this pixel.
  logic has_up;
  logic has_up2;
  logic has_left;
  logic has_left2;
  logic peak_up;
  logic peak_left;
  logic peak_here;

  always_comb begin
    has_up    = (row_pos != '0);
    has_up2   = (32'(row_pos) >= 32'd2);
    has_left  = (col_pos != '0);
    has_left2 = (32'(col_pos) >= 32'd2);
    peak_up   = has_up
                && !(has_up2 && (above2 > above))
                && !(pixel > above)
                && !(has_left && (left2_pixel > above))
                && !(!last_col && (right_above > above));
    peak_left = last_row && has_left
                && !(has_up && (left2_pixel > left_pixel))
                && !(has_left2 && (left_left_pixel > left_pixel))
                && !(pixel > left_pixel);
    peak_here = last_row && last_col
                && !(has_up && (above > pixel))
                && !(has_left && (left_pixel > pixel));
  end

  // Result items in emission order, with running counts.
  result_t    res_up;
  result_t    res_left;
  result_t    res_here;
  result_t    res_first;
  result_t    res_second;
  logic [1:0] push_n;
  logic [31:0] row_p2;

  always_comb begin
    row_p2         = row_p1;
    res_up.row     = row_pos[ROW_W-1:0] == '0 ? '0 : ROW_OUT_W'(32'(row_pos));
    res_up.col     = col_p1[COL_OUT_W-1:0];
    res_up.count   = peak_total + CNT_W'(1);
    res_up.last    = !(peak_left || peak_here);
    res_left.row   = row_p2[ROW_OUT_W-1:0];
    res_left.col   = COL_OUT_W'(32'(col_pos));
    res_left.count = peak_total + CNT_W'(peak_up) + CNT_W'(1);
    res_left.last  = !peak_here;
    res_here.row   = row_p2[ROW_OUT_W-1:0];
    res_here.col   = col_p1[COL_OUT_W-1:0];
    res_here.count = peak_total + CNT_W'(peak_up) + CNT_W'(peak_left) + CNT_W'(1);
    res_here.last  = 1'b1;

    push_n = 2'(peak_up) + 2'(peak_left) + 2'(peak_here);

    // Pack the valid results to the front.
    if (peak_up) begin
      res_first = res_up;
    end else if (peak_left) begin
      res_first = res_left;
    end else begin
      res_first = res_here;
    end
    res_second = (peak_up && peak_left) ? res_left : res_here;
  end

  // Position, peak total and neighbor updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos    <= '0;
      col_pos    <= '0;
      peak_total <= '0;
    end else if (in_accept) begin
      row_pos    <= row_next;
      col_pos    <= col_next;
      peak_total <= (last_row && last_col) ? '0 : peak_total + CNT_W'(push_n);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      left_left_pixel <= left_pixel;
      left_pixel      <= pixel;
      left2_pixel     <= above;
    end
  end

  // Result queue storage: up to three entries written per pixel.
  always_ff @(posedge clk) begin
    logic [OQ_PTR_W-1:0] slot;
    for (int i = 0; i < OQ_DEPTH; i++) begin
      slot = OQ_PTR_W'(i) - oq_wptr;
      if (in_accept) begin
        if (slot == OQ_PTR_W'(0) && push_n >= 2'd1) begin
          oq_mem[i] <= res_first;
        end else if (slot == OQ_PTR_W'(1) && push_n >= 2'd2) begin
          oq_mem[i] <= res_second;
        end else if (slot == OQ_PTR_W'(2) && push_n == 2'd3) begin
          oq_mem[i] <= res_here;
        end
      end
    end
  end

  // Result queue pointers and fill count.
  logic [1:0] push_acc;

  assign push_acc = in_accept ? push_n : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wptr  <= '0;
      oq_rptr  <= '0;
      oq_count <= '0;
    end else begin
      oq_wptr  <= oq_wptr + OQ_PTR_W'(push_acc);
      oq_rptr  <= oq_rptr + OQ_PTR_W'(out_accept);
      oq_count <= oq_count + OQ_CNT_W'(push_acc) - OQ_CNT_W'(out_accept);
    end
  end

  // Output item from the queue head.
  result_t head;

  assign head    = oq_mem[oq_rptr];
  assign m_tdata = {1'b0, head.count, head.col, head.row};
  assign m_tlast = head.last;

  // The queue never holds more items than it has entries.
  assert property (@(posedge clk) disable iff (rst)
    oq_count <= OQ_CNT_W'(OQ_DEPTH))
    else $error("result queue overfilled");

  // The last pixel of a frame returns position and peak total to zero.
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && last_row && last_col)
    |=> (row_pos == '0 && col_pos == '0 && peak_total == '0))
    else $error("frame end did not restart the frame state");

  // Forwarded read data only follows a line buffer write.
  assert property (@(posedge clk) disable iff (rst)
    (fwd_here || fwd_right) |-> $past(in_accept))
    else $error("forwarding without a preceding write");

endmodule

`default_nettype wire

// ===== design/rlmf_ram.sv =====
// ----------------------------------------------------------------------------
// rlmf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module rlmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
